// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled during reset.
`define CHK_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define CHK_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== design/mexp_pkg.sv =====
// Package with the payload types and constants of the modular exponentiation unit.
package mexp_pkg;

  localparam int unsigned WORD_W = 128;
  localparam int unsigned PROD_W = 256;
  localparam int unsigned HALF_W = 64;

  typedef struct packed {
    logic [HALF_W-1:0] exponent_high;
    logic [HALF_W-1:0] exponent_low;
    logic [HALF_W-1:0] base_high;
    logic [HALF_W-1:0] base_low;
  } mexp_in_t;

  typedef struct packed {
    logic              modulus_error;
    logic [HALF_W-1:0] result_high;
    logic [HALF_W-1:0] result_low;
  } mexp_out_t;

  // Job handed from the front part to the back part.
  typedef struct packed {
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] exponent;
    logic [WORD_W-1:0] modulus;
    logic              zero_mod;
  } mexp_job_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_HIGH = 1'b1;

endpackage

// ===== design/mexp_front.sv =====
// Front part: takes items, classifies the modulus and queues jobs for the back part.
module mexp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  mexp_pkg::mexp_in_t    in_data,
  input  logic [mexp_pkg::WORD_W-1:0] modulus,
  output logic                  job_valid,
  input  logic                  job_take,
  output mexp_pkg::mexp_job_t   job
);
  import mexp_pkg::*;

  // Two-entry job queue.
  mexp_job_t q_r [2];
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic      do_push, do_pop;
  mexp_job_t new_job;

  assign in_full   = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = job_take && job_valid;

  always_comb begin
    new_job.base     = {in_data.base_high, in_data.base_low};
    new_job.exponent = {in_data.exponent_high, in_data.exponent_low};
    new_job.modulus  = modulus;
    new_job.zero_mod = (modulus == '0);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/mexp_back.sv =====
// Back part: sequencer with a shared shift-add multiplier and restoring reducer.
module mexp_back #(
  parameter int unsigned EXP_BITS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_take,
  input  mexp_pkg::mexp_job_t job,
  output logic                out_empty,
  input  logic                out_pop,
  output mexp_pkg::mexp_out_t out_data
);
  import mexp_pkg::*;

  localparam int unsigned BIT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int unsigned MCNT_W = $clog2(WORD_W);
  localparam int unsigned RCNT_W = $clog2(PROD_W);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_MUL, S_RED, S_NEXT, S_DONE
  } state_t;

  state_t               state_r;
  logic [WORD_W-1:0]    acc_r, pw_r, ex_r, mod_r;
  logic [BIT_W-1:0]     bit_r;
  logic                 sq_r;        // current product is the squaring
  logic [WORD_W-1:0]    mcand_r, mplier_r;
  logic [PROD_W-1:0]    prod_r;
  logic [MCNT_W-1:0]    mcnt_r;
  logic [RCNT_W-1:0]    rcnt_r;
  logic [WORD_W:0]      rem_r;
  logic                 out_valid_r;
  mexp_out_t            out_r;

  logic [PROD_W-1:0]    prod_nxt;
  logic [WORD_W:0]      shl, diff;
  logic                 last_bit;

  assign job_take  = (state_r == S_IDLE) && job_valid && !out_valid_r;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign last_bit  = (bit_r == BIT_W'(EXP_BITS - 1));

  // One multiplier bit per cycle, MSB first: prod = 2*prod + (bit ? mcand : 0).
  always_comb begin
    prod_nxt = {prod_r[PROD_W-2:0], 1'b0} +
               (mplier_r[WORD_W-1] ? {{(PROD_W-WORD_W){1'b0}}, mcand_r} : '0);
    shl  = {rem_r[WORD_W-1:0], prod_r[PROD_W-1]};
    diff = shl - {1'b0, mod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_take) begin
            acc_r     <= {{(WORD_W-1){1'b0}}, 1'b1};
            pw_r      <= job.base;
            ex_r      <= job.exponent;
            mod_r     <= job.modulus;
            bit_r     <= '0;
            sq_r      <= 1'b0;
            if (job.zero_mod) begin
              out_r.result_low    <= '0;
              out_r.result_high   <= '0;
              out_r.modulus_error <= 1'b1;
              state_r             <= S_DONE;
            end else begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          // Either multiply the result by the power, or square the power.
          mcnt_r <= '0;
          prod_r <= '0;
          if (!sq_r && ex_r[0]) begin
            mcand_r  <= acc_r;
            mplier_r <= pw_r;
            state_r  <= S_MUL;
          end else if (!last_bit) begin
            sq_r     <= 1'b1;
            mcand_r  <= pw_r;
            mplier_r <= pw_r;
            state_r  <= S_MUL;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_MUL: begin
          prod_r   <= prod_nxt;
          mplier_r <= {mplier_r[WORD_W-2:0], 1'b0};
          mcnt_r   <= mcnt_r + 1'b1;
          if (mcnt_r == MCNT_W'(WORD_W - 1)) begin
            rem_r   <= '0;
            rcnt_r  <= '0;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          // Restoring reduction, one product bit per cycle from the top.
          prod_r <= {prod_r[PROD_W-2:0], 1'b0};
          rem_r  <= diff[WORD_W] ? shl : diff;
          rcnt_r <= rcnt_r + 1'b1;
          if (rcnt_r == RCNT_W'(PROD_W - 1)) begin
            if (sq_r) begin
              pw_r    <= diff[WORD_W] ? shl[WORD_W-1:0] : diff[WORD_W-1:0];
              state_r <= S_NEXT;
            end else begin
              acc_r   <= diff[WORD_W] ? shl[WORD_W-1:0] : diff[WORD_W-1:0];
              state_r <= last_bit ? S_NEXT : S_DECIDE;
              if (!last_bit) begin
                ex_r <= {ex_r[WORD_W-1:1], 1'b0};
              end
            end
          end
        end
        S_NEXT: begin
          sq_r <= 1'b0;
          ex_r <= {1'b0, ex_r[WORD_W-1:1]};
          if (last_bit) begin
            out_r.result_low    <= acc_r[HALF_W-1:0];
            out_r.result_high   <= acc_r[WORD_W-1:HALF_W];
            out_r.modulus_error <= 1'b0;
            state_r             <= S_DONE;
          end else begin
            bit_r   <= bit_r + 1'b1;
            state_r <= S_DECIDE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/modular_exponentiation_128_unit.sv =====
// Top level of the 128-bit modular exponentiation unit.
// The unit computes base^exponent mod modulus by right-to-left binary
// exponentiation over the low EXP_BITS exponent bits, with the modulus taken
// from two 64-bit configuration registers (index 0 low half, index 1 high
// half). Every item gives one result item. A zero modulus raises
// modulus_error and returns zero; a zero exponent returns one, unreduced.
// Items are accepted into a two-entry job queue, and a single back-end
// sequencer works on one item at a time. Each modular product passes through
// the shift-add multiplier and then the bit-serial restoring reducer. An item
// needs up to 2*EXP_BITS-1 products, and about three quarters of that for a
// typical exponent with half of its bits set. A zero modulus needs no product
// at all. The result waits in an output register until popped, while the
// queue keeps taking new items.
module modular_exponentiation_128_unit #(
  parameter int unsigned EXP_BITS = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  mexp_pkg::mexp_in_t         in_data,
  output logic                       out_empty,
  input  logic                       out_pop,
  output mexp_pkg::mexp_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mexp_pkg::HALF_W-1:0]    cfg_wdata
);
  import mexp_pkg::*;

  logic [HALF_W-1:0] mod_low_r, mod_high_r;
  logic              job_valid, job_take;
  mexp_job_t         job;

  // Configuration registers; the modulus is sampled into each job on entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_low_r  <= '0;
      mod_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOD_LOW:  mod_low_r  <= cfg_wdata;
        REG_MOD_HIGH: mod_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mexp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .modulus   ({mod_high_r, mod_low_r}),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  mexp_back #(.EXP_BITS(EXP_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== design/mexp_checker.sv =====
// Port-level checker for the modular exponentiation unit, with its bind.
`include "assert_macros.svh"
module mexp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input mexp_pkg::mexp_out_t out_data
);
  import mexp_pkg::*;

  `CHK_ASSERT(a_err_zero, clk, rst_n, (!out_empty && out_data.modulus_error) |-> (out_data.result_low == '0 && out_data.result_high == '0), "error result not zero")
  `CHK_ASSERT(a_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "waiting result changed")
  `CHK_ASSERT(a_pop_empties, clk, rst_n, (out_pop && !out_empty) |=> out_empty, "result not removed after pop")
  `CHK_ASSERT(a_full_from_push, clk, rst_n, $rose(in_full) |-> $past(in_push), "queue filled without a push")
  `CHK_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> (out_empty && !in_full), "reset state wrong")
endmodule

bind modular_exponentiation_128_unit mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 128-bit modular exponentiation unit.
module testbench;
  import mexp_pkg::*;

  // The clock period is 4 ns, and reset is held low at the start.
  localparam int unsigned HALF_PERIOD = 2;
  localparam int unsigned RESET_CYCLES = 9;
  // STALL_LIMIT bounds how long the watchdog waits with no handshake at all.
  localparam int unsigned STALL_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 96;
  localparam int unsigned DIRECTED_ROWS = 16;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  mexp_in_t             in_data = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  mexp_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MOD_LOW;
  logic [HALF_W-1:0]    cfg_wdata = '0;

  modular_exponentiation_128_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // This is the testbench's own copy of the configured modulus.
  logic [WORD_W-1:0] modulus_now = '0;
  // These are the modular powers still waiting to come out, oldest first.
  mexp_out_t         pending_powers[$];
  int unsigned       mismatches = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       quiet_cycles = 0;

  // Each modular product is reduced in full, which is what the restoring reducer yields.
  function automatic logic [WORD_W-1:0] mul_mod(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] n);
    logic [PROD_W-1:0] prod;
    prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
    return WORD_W'(prod % {{WORD_W{1'b0}}, n});
  endfunction

  // The exponent is scanned from bit 0 upwards.
  // The running power starts at one and is left unreduced when no exponent bit is set.
  function automatic mexp_out_t modular_power(input logic [WORD_W-1:0] base,
                                              input logic [WORD_W-1:0] expo,
                                              input logic [WORD_W-1:0] n);
    mexp_out_t         res;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] sq;
    res = '0;
    if (n == '0) begin
      res.modulus_error = 1'b1;
      return res;
    end
    acc = 1;
    sq = base;
    for (int i = 0; i < WORD_W; i++) begin
      if (expo[i]) begin
        acc = mul_mod(acc, sq, n);
      end
      if (i < WORD_W - 1) begin
        sq = mul_mod(sq, sq, n);
      end
    end
    res.result_low = acc[HALF_W-1:0];
    res.result_high = acc[WORD_W-1:HALF_W];
    return res;
  endfunction

  // The receiver decides at each falling edge whether it will take a result.
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Each popped result is compared with the oldest modular power still waiting.
  always @(posedge clk) begin
    mexp_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_powers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item %h", $time, out_data);
      end else begin
        want = pending_powers.pop_front();
        if (out_data.result_low !== want.result_low) begin
          mismatches++;
          $display("%0t: result_low expected %h actual %h", $time, want.result_low,
                   out_data.result_low);
        end
        if (out_data.result_high !== want.result_high) begin
          mismatches++;
          $display("%0t: result_high expected %h actual %h", $time, want.result_high,
                   out_data.result_high);
        end
        if (out_data.modulus_error !== want.modulus_error) begin
          mismatches++;
          $display("%0t: modulus_error expected %b actual %b", $time, want.modulus_error,
                   out_data.modulus_error);
        end
      end
    end
  end

  // The watchdog counts the cycles in which neither side completes a handshake.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One item is offered after a random idle gap and held until the unit takes it.
  // The expected power is queued at the edge where the item is accepted.
  task automatic send_item(input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] expo,
                           input bit known, input mexp_out_t known_power);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
    end
    in_data = {expo, base};
    in_push = 1'b1;
    do begin
      @(posedge clk);
    end while (in_full);
    pending_powers.push_back(known ? known_power : modular_power(base, expo, modulus_now));
    @(negedge clk);
    in_push = 1'b0;
  endtask

  // The modulus is only changed once the unit has delivered every result.
  task automatic set_modulus(input logic [WORD_W-1:0] n);
    while (pending_powers.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = REG_MOD_LOW;
    cfg_wdata = n[HALF_W-1:0];
    @(negedge clk);
    cfg_index = REG_MOD_HIGH;
    cfg_wdata = n[WORD_W-1:HALF_W];
    @(negedge clk);
    cfg_we = 1'b0;
    modulus_now = n;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  typedef struct {
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] expo;
    bit                known;
    mexp_out_t         power;
  } stim_row_t;

  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
  localparam mexp_out_t ERR_POWER = '{modulus_error: 1'b1, result_high: '0, result_low: '0};
  localparam mexp_out_t ONE_POWER = '{modulus_error: 1'b0, result_high: '0, result_low: 1};
  localparam mexp_out_t ZERO_POWER = '0;

  stim_row_t plan[DIRECTED_ROWS];

  initial begin
    logic [WORD_W-1:0] next_mod;
    logic [WORD_W-1:0] expo;

    // The first row runs on the reset modulus of zero, so the unit must flag an error.
    // Later rows cover a zero exponent, including the case where one is returned
    // unreduced with a modulus of one.
    // They also cover a base above the modulus, the all-ones extremes,
    // and the lowest and highest exponent bits.
    plan = '{
      '{'0, ONES, ONES, 1'b1, ERR_POWER},
      '{'0, 5, '0, 1'b1, ERR_POWER},
      '{5, 3, '0, 1'b1, ONE_POWER},
      '{1, 9, '0, 1'b1, ONE_POWER},
      '{1, 9, 5, 1'b1, ZERO_POWER},
      '{1000, 2, 1, 1'b1, '{1'b0, 64'd0, 64'd2}},
      '{7, 100, 1, 1'b1, '{1'b0, 64'd0, 64'd2}},
      '{ONES, '0, 1, 1'b1, ZERO_POWER},
      '{ONES, ONES, 1, 1'b1, ZERO_POWER},
      '{ONES, ONES - 1, ONES, 1'b0, ZERO_POWER},
      '{ONES, 3, {1'b1, 127'b0}, 1'b0, ZERO_POWER},
      '{{1'b1, 127'b0}, 3, ONES, 1'b0, ZERO_POWER},
      '{{64'b0, {64{1'b1}}}, ONES, 12345, 1'b0, ZERO_POWER},
      '{{{64{1'b1}}, 64'b0}, 7, ONES, 1'b0, ZERO_POWER},
      '{1, ONES, ONES, 1'b1, ZERO_POWER},
      '{'0, ONES, 1, 1'b1, ERR_POWER}
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // The directed part runs in the first idling phase, and the modulus is only
    // rewritten when a row asks for a different value.
    send_idle_pct = 32;
    recv_idle_pct = 61;
    foreach (plan[i]) begin
      if (i > 0 && plan[i].modulus != modulus_now) begin
        set_modulus(plan[i].modulus);
      end
      send_item(plan[i].base, plan[i].expo, plan[i].known, plan[i].power);
    end

    // The random part has three idling phases.
    // A fresh modulus is chosen every eight items, and the extreme values appear now and then.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 0) begin
        send_idle_pct = 32;
        recv_idle_pct = 61;
      end else if (k == RANDOM_ITEMS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 32;
      end else if (k == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (k % 8 == 0) begin
        case ($urandom_range(9))
          0:       next_mod = '0;
          1:       next_mod = ONES;
          2:       next_mod = 1;
          3:       next_mod = WORD_W'($urandom_range(1000, 2));
          4:       next_mod = {rand_word() >> $urandom_range(127)};
          default: next_mod = rand_word();
        endcase
        set_modulus(next_mod);
      end
      // Short exponents stress the lower bits, while full-width exponents exercise the rest.
      case ($urandom_range(5))
        0:       expo = WORD_W'($urandom_range(3));
        1:       expo = rand_word() >> $urandom_range(127);
        default: expo = rand_word();
      endcase
      send_item(rand_word(), expo, 1'b0, ZERO_POWER);
    end

    while (pending_powers.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
